// File: src/cdd_pkg.sv
package cdd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 22;
  localparam int ORD_W  = 2;

  // Quotients by 100 of a clamped year stay below 100.
  localparam int Q_W = 7;
  localparam int DBM_W = 9;

  localparam int MAX_YEAR    = 9999;
  localparam int COUNT_MAX   = 4194303;
  localparam int DAYS_COMMON = 365;
  localparam int CENTURY     = 100;

  // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for every v below 2**14.
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = YEAR_W + RECIP_W;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_MAR = 4'd3;
  localparam logic [MON_W-1:0] MON_MAY = 4'd5;
  localparam logic [MON_W-1:0] MON_JUL = 4'd7;
  localparam logic [MON_W-1:0] MON_AUG = 4'd8;
  localparam logic [MON_W-1:0] MON_OCT = 4'd10;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  typedef enum logic [ORD_W-1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } cdd_order_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day_first;
    logic [MON_W-1:0]  month_first;
    logic [YEAR_W-1:0] year_first;
    logic [DAY_W-1:0]  day_second;
    logic [MON_W-1:0]  month_second;
    logic [YEAR_W-1:0] year_second;
  } cdd_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] day_count;
    logic [ORD_W-1:0] order;
    logic             first_valid;
    logic             second_valid;
  } cdd_out_t;

  // Days before the first of each month in a common year. Month 0 has none,
  // and the month numbers past December run on at 30 days each.
  localparam logic [DBM_W-1:0] DAYS_BEFORE_MONTH [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd395, 9'd425
  };

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == MON_JAN || m == MON_MAR || m == MON_MAY || m == MON_JUL ||
                 m == MON_AUG || m == MON_OCT || m == MON_DEC) begin
      len = 5'd31;
    end else begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

// File: src/calendar_day_difference_unit.sv
// Throughput: one date pair per cycle unless out_stall holds the pipeline;
// the four pipeline stages each hold a valid bit and advance whenever the
// stage ahead of them can take their data.
// Reset (rst_n low, synchronous) clears every stage valid bit, so no result
// is shown after reset until a new input transfer has passed the pipeline.
module calendar_day_difference_unit import cdd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cdd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cdd_out_t out_data
);

  // Both dates are handled in two identical lanes: lane 0 is the first
  // date, lane 1 the second.

  // Stage enables. A stage loads when it is empty or when its own content
  // moves on in the same cycle, so a stall backs up stage by stage and
  // bubbles are squeezed out.
  logic st1_vld_r, st2_vld_r, st3_vld_r, st4_vld_r;
  logic st1_en, st2_en, st3_en, st4_en;

  assign st4_en   = !st4_vld_r || !out_stall;
  assign st3_en   = !st3_vld_r || st4_en;
  assign st2_en   = !st2_vld_r || st3_en;
  assign st1_en   = !st1_vld_r || st2_en;
  assign in_stall = !st1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
      st2_vld_r <= 1'b0;
      st3_vld_r <= 1'b0;
      st4_vld_r <= 1'b0;
    end else begin
      if (st1_en) st1_vld_r <= in_valid;
      if (st2_en) st2_vld_r <= st1_vld_r;
      if (st3_en) st3_vld_r <= st2_vld_r;
      if (st4_en) st4_vld_r <= st3_vld_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp the years to the supported range and order the dates.
  // The order compares the clamped year, then month, then day.
  // ---------------------------------------------------------------------
  logic [YEAR_W-1:0] yr_raw [2];
  logic [YEAR_W-1:0] yr_clamp [2];
  logic [YEAR_W-1:0] st1_year_r [2];
  logic [MON_W-1:0]  st1_mon_r [2];
  logic [DAY_W-1:0]  st1_day_r [2];
  cdd_order_t        ord_nxt, st1_ord_r;

  assign yr_raw[0] = in_data.year_first;
  assign yr_raw[1] = in_data.year_second;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      yr_clamp[i] = (yr_raw[i] > YEAR_W'(MAX_YEAR)) ? YEAR_W'(MAX_YEAR) : yr_raw[i];
    end
    if (yr_clamp[0] != yr_clamp[1]) begin
      ord_nxt = (yr_clamp[0] > yr_clamp[1]) ? ORD_LATER : ORD_EARLIER;
    end else if (in_data.month_first != in_data.month_second) begin
      ord_nxt = (in_data.month_first > in_data.month_second) ? ORD_LATER : ORD_EARLIER;
    end else if (in_data.day_first != in_data.day_second) begin
      ord_nxt = (in_data.day_first > in_data.day_second) ? ORD_LATER : ORD_EARLIER;
    end else begin
      ord_nxt = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_en) begin
      st1_year_r[0] <= yr_clamp[0];
      st1_year_r[1] <= yr_clamp[1];
      st1_mon_r[0]  <= in_data.month_first;
      st1_mon_r[1]  <= in_data.month_second;
      st1_day_r[0]  <= in_data.day_first;
      st1_day_r[1]  <= in_data.day_second;
      st1_ord_r     <= ord_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the multiplications. The year and the year minus one are each
  // divided by 100 through a reciprocal product, and 365 times the year is
  // formed for the day count of the whole years.
  // ---------------------------------------------------------------------
  logic [YEAR_W-1:0] yr_less1 [2];
  logic [PROD_W-1:0] prod_y [2];
  logic [PROD_W-1:0] prod_n [2];
  logic [CNT_W-1:0]  y365 [2];
  logic [Q_W-1:0]    st2_qy_r [2];
  logic [Q_W-1:0]    st2_qn_r [2];
  logic [CNT_W-1:0]  st2_y365_r [2];
  logic [YEAR_W-1:0] st2_year_r [2];
  logic [MON_W-1:0]  st2_mon_r [2];
  logic [DAY_W-1:0]  st2_day_r [2];
  cdd_order_t        st2_ord_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      yr_less1[i] = st1_year_r[i] - YEAR_W'(1);
      prod_y[i]   = PROD_W'(st1_year_r[i]) * PROD_W'(RECIP_100);
      prod_n[i]   = PROD_W'(yr_less1[i]) * PROD_W'(RECIP_100);
      y365[i]     = CNT_W'(st1_year_r[i]) * CNT_W'(DAYS_COMMON);
    end
  end

  always_ff @(posedge clk) begin
    if (st2_en) begin
      for (int i = 0; i < 2; i++) begin
        st2_qy_r[i]   <= prod_y[i][RECIP_SHIFT +: Q_W];
        st2_qn_r[i]   <= prod_n[i][RECIP_SHIFT +: Q_W];
        st2_y365_r[i] <= y365[i];
        st2_year_r[i] <= st1_year_r[i];
        st2_mon_r[i]  <= st1_mon_r[i];
        st2_day_r[i]  <= st1_day_r[i];
      end
      st2_ord_r <= st1_ord_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: leap rule, day number of each date and the validity checks.
  // The day number counts from the first of January of year zero; the
  // leap days of the years before are (y-1)/4 - (y-1)/100 + (y-1)/400 plus
  // the one of year zero itself. Bad months and days still yield a count.
  // ---------------------------------------------------------------------
  logic [YEAR_W-1:0] n_yr [2];
  logic [YEAR_W-1:0] cent_y [2];
  logic              div100 [2];
  logic              leap [2];
  logic [CNT_W:0]    dby [2];
  logic [CNT_W:0]    dnum [2];
  logic [DAY_W-1:0]  mlen [2];
  logic              dvalid [2];
  logic [CNT_W-1:0]  st3_dnum_r [2];
  logic              st3_dvalid_r [2];
  cdd_order_t        st3_ord_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      n_yr[i]   = st2_year_r[i] - YEAR_W'(1);
      cent_y[i] = YEAR_W'(st2_qy_r[i]) * YEAR_W'(CENTURY);
      div100[i] = (cent_y[i] == st2_year_r[i]);
      leap[i]   = div100[i] ? (st2_qy_r[i][1:0] == 2'b00)
                            : (st2_year_r[i][1:0] == 2'b00);
      if (st2_year_r[i] == '0) begin
        dby[i] = '0;
      end else begin
        dby[i] = (CNT_W+1)'(st2_y365_r[i]) + (CNT_W+1)'(1)
               + (CNT_W+1)'(n_yr[i] >> 2) + (CNT_W+1)'(st2_qn_r[i] >> 2)
               - (CNT_W+1)'(st2_qn_r[i]);
      end
      dnum[i] = dby[i] + (CNT_W+1)'(DAYS_BEFORE_MONTH[st2_mon_r[i]])
              + (CNT_W+1)'((st2_mon_r[i] > MON_FEB) && leap[i])
              + (CNT_W+1)'(st2_day_r[i]);
      mlen[i]   = month_len(st2_mon_r[i], leap[i]);
      dvalid[i] = (st2_mon_r[i] >= MON_JAN) && (st2_mon_r[i] <= MON_DEC) &&
                  (st2_day_r[i] != '0) && (st2_day_r[i] <= mlen[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (st3_en) begin
      for (int i = 0; i < 2; i++) begin
        st3_dnum_r[i]   <= dnum[i][CNT_W-1:0];
        st3_dvalid_r[i] <= dvalid[i];
      end
      st3_ord_r <= st2_ord_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: absolute difference of the day numbers into the output
  // register. Equal dates force a zero count; the count saturates at the
  // field maximum.
  // ---------------------------------------------------------------------
  logic [CNT_W:0]   diff;
  logic [CNT_W:0]   diff_abs;
  logic [CNT_W-1:0] cnt;
  cdd_out_t         out_nxt, out_r;

  always_comb begin
    diff     = (CNT_W+1)'(st3_dnum_r[1]) - (CNT_W+1)'(st3_dnum_r[0]);
    diff_abs = diff[CNT_W] ? (~diff + (CNT_W+1)'(1)) : diff;
    if (st3_ord_r == ORD_EQUAL) begin
      cnt = '0;
    end else if (diff_abs > (CNT_W+1)'(COUNT_MAX)) begin
      cnt = CNT_W'(COUNT_MAX);
    end else begin
      cnt = diff_abs[CNT_W-1:0];
    end
    out_nxt.day_count    = cnt;
    out_nxt.order        = st3_ord_r;
    out_nxt.first_valid  = st3_dvalid_r[0];
    out_nxt.second_valid = st3_dvalid_r[1];
  end

  always_ff @(posedge clk) begin
    if (st4_en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = st4_vld_r;
  assign out_data  = out_r;

endmodule

// File: src/cdd_checker.sv
module cdd_checker import cdd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input cdd_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input cdd_out_t out_data
);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Equal dates always report a zero day count.
  a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.order == ORD_EQUAL |-> out_data.day_count == '0)
    else $error("equal dates with nonzero count");

  // A transfer of two identical dates comes out of the pipeline as equal
  // when nothing stalls in between.
  a_same_dates: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.day_first == in_data.day_second &&
    in_data.month_first == in_data.month_second &&
    in_data.year_first == in_data.year_second && !out_stall ##1 !out_stall
    ##1 !out_stall ##1 !out_stall |=> out_valid && out_data.order == ORD_EQUAL)
    else $error("identical dates not reported equal");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind calendar_day_difference_unit cdd_checker u_cdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/tb.sv
module tb;
  import cdd_pkg::*;

  // The watchdog ends the run after this many cycles without any transfer.
  // The longest correct quiet spell is one sender gap or a chain of stall
  // bursts, added to the pipeline depth, so the margin is wide.
  localparam int QUIET_LIMIT  = 4000;
  // Cycles to wait after the last result. This covers the pipeline depth with
  // some room, so that a stray extra result can still show up.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 750;
  // The last stretch of the random part runs with no gaps and no stalls.
  localparam int CALM_TAIL    = 100;
  localparam int PHASE_LEN    = 75;
  localparam int YEAR_TOP     = (1 << YEAR_W) - 1;

  // Days before the first of month m in a common year. Month 0 has none, and
  // the month numbers past December keep adding 30 days each.
  localparam int unsigned MONTH_OFFSET [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 395, 425
  };

  typedef struct packed {
    cdd_in_t  pair;
    bit       typed;   // golden below was worked out by hand
    cdd_out_t golden;
  } probe_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  cdd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cdd_out_t out_data;

  // Results still owed by the block, oldest first.
  cdd_out_t gaps_due [$];
  int       miss_count   = 0;
  int       quiet_cycles = 0;
  // Chance in percent, per cycle, that the receiver starts a stall burst.
  int       stall_pct    = 0;
  int       stall_left   = 0;
  // When set, the sender may insert an idle gap before each item.
  bit       gaps_on      = 1'b0;

  calendar_day_difference_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the prediction.
  // ---------------------------------------------------------------------------

  // A year is a leap year when it is divisible by 400, or when it is divisible
  // by 4 but not by 100. Year 0 counts as a leap year.
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      2:                  return leap_year(y) ? 29 : 28;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default:            return 30;
    endcase
  endfunction

  // Running day number counted from the first of January of year 0. The day
  // is used as given, so day 0 or a day past the end of the month just moves
  // the number back or forward.
  function automatic longint day_index(int unsigned d, int unsigned m, int unsigned y);
    longint idx = 0;
    longint n;
    if (y != 0) begin
      n   = y - 1;
      idx = 365 * longint'(y) + 1 + n / 4 - n / 100 + n / 400;
    end
    idx += MONTH_OFFSET[m];
    if (m > 2 && leap_year(y)) begin
      idx += 1;
    end
    return idx + d;
  endfunction

  function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
    return (m >= 1) && (m <= 12) && (d >= 1) && (d <= days_in_month(m, y));
  endfunction

  // Expected result for one date pair. Years past MAX_YEAR are clamped before
  // anything else, so they also affect the order, the leap rule and validity.
  function automatic cdd_out_t predict_gap(cdd_in_t p);
    cdd_out_t    r;
    int unsigned y1;
    int unsigned y2;
    longint      span;
    y1 = (p.year_first > MAX_YEAR) ? MAX_YEAR : p.year_first;
    y2 = (p.year_second > MAX_YEAR) ? MAX_YEAR : p.year_second;

    // The order compares the clamped year, then the raw month, then the raw
    // day. An invalid date can therefore be "later" while its day number
    // is smaller.
    if (y1 != y2) begin
      r.order = (y1 > y2) ? ORD_LATER : ORD_EARLIER;
    end else if (p.month_first != p.month_second) begin
      r.order = (p.month_first > p.month_second) ? ORD_LATER : ORD_EARLIER;
    end else if (p.day_first != p.day_second) begin
      r.order = (p.day_first > p.day_second) ? ORD_LATER : ORD_EARLIER;
    end else begin
      r.order = ORD_EQUAL;
    end

    span = day_index(p.day_second, p.month_second, y2) -
           day_index(p.day_first, p.month_first, y1);
    if (r.order == ORD_EQUAL) begin
      span = 0;
    end
    if (span < 0) begin
      span = -span;
    end
    if (span > COUNT_MAX) begin
      span = COUNT_MAX;
    end
    r.day_count    = span[CNT_W-1:0];
    r.first_valid  = date_ok(p.day_first, p.month_first, y1);
    r.second_valid = date_ok(p.day_second, p.month_second, y2);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic cdd_in_t date_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                                        int unsigned d2, int unsigned m2, int unsigned y2);
    cdd_in_t p;
    p.day_first    = DAY_W'(d1);
    p.month_first  = MON_W'(m1);
    p.year_first   = YEAR_W'(y1);
    p.day_second   = DAY_W'(d2);
    p.month_second = MON_W'(m2);
    p.year_second  = YEAR_W'(y2);
    return p;
  endfunction

  // A directed row whose result comes from the predictor.
  function automatic probe_t check_row(int unsigned d1, int unsigned m1, int unsigned y1,
                                       int unsigned d2, int unsigned m2, int unsigned y2);
    probe_t r;
    r.pair   = date_pair(d1, m1, y1, d2, m2, y2);
    r.typed  = 1'b0;
    r.golden = '0;
    return r;
  endfunction

  // A directed row whose result is written out by hand.
  function automatic probe_t known_row(int unsigned d1, int unsigned m1, int unsigned y1,
                                       int unsigned d2, int unsigned m2, int unsigned y2,
                                       int unsigned cnt, cdd_order_t ord, bit v1, bit v2);
    probe_t r;
    r.pair                = date_pair(d1, m1, y1, d2, m2, y2);
    r.typed               = 1'b1;
    r.golden.day_count    = CNT_W'(cnt);
    r.golden.order        = ord;
    r.golden.first_valid  = v1;
    r.golden.second_valid = v2;
    return r;
  endfunction

  // Random date pairs. Most are valid dates spread over the whole year range,
  // with extra weight on pairs that share a year or a month, on equal dates,
  // on clamped years, on the end of February, and on fully random field bits.
  function automatic cdd_in_t random_pair();
    cdd_in_t     p;
    logic [63:0] raw;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    p.year_first   = YEAR_W'($urandom_range(0, MAX_YEAR));
    p.month_first  = MON_W'($urandom_range(1, 12));
    p.day_first    = DAY_W'($urandom_range(1, days_in_month(p.month_first, p.year_first)));
    p.year_second  = YEAR_W'($urandom_range(0, MAX_YEAR));
    p.month_second = MON_W'($urandom_range(1, 12));
    p.day_second   = DAY_W'($urandom_range(1, days_in_month(p.month_second, p.year_second)));
    if (pick < 15) begin
      // Close dates: same year, and half of the time the same month.
      p.year_second = p.year_first;
      if (pick < 8) begin
        p.month_second = p.month_first;
      end
      p.day_second = DAY_W'($urandom_range(1, days_in_month(p.month_second, p.year_second)));
    end else if (pick < 25) begin
      p.day_second   = p.day_first;
      p.month_second = p.month_first;
      p.year_second  = p.year_first;
    end else if (pick < 35) begin
      // Years at or past the limit on one or both sides.
      p.year_first = YEAR_W'($urandom_range(MAX_YEAR, YEAR_TOP));
      if (pick < 30) begin
        p.year_second = YEAR_W'($urandom_range(MAX_YEAR, YEAR_TOP));
      end
    end else if (pick < 47) begin
      raw = {$urandom(), $urandom()};
      p   = raw[$bits(cdd_in_t)-1:0];
    end else if (pick < 55) begin
      // End of February around leap and century years.
      p.year_first   = YEAR_W'(4 * $urandom_range(0, MAX_YEAR / 4));
      p.month_first  = MON_FEB;
      p.day_first    = DAY_W'($urandom_range(28, 29));
      p.year_second  = YEAR_W'(p.year_first + $urandom_range(0, 1));
      p.month_second = MON_W'($urandom_range(2, 3));
      p.day_second   = DAY_W'($urandom_range(1, 29));
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offers one pair, optionally after an idle gap, and holds it until the
  // block takes it. The expected result is queued at the transfer edge.
  task automatic send_pair(input cdd_in_t p, input cdd_out_t due);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    gaps_due.push_back(due);
  endtask

  // Holds the sender off until every queued result has come back. It always
  // waits on the clock before it checks the queue, so valid is never lowered
  // and raised again within one time step.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gaps_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    probe_t  rows [$];
    cdd_in_t p;

    // Extremes of every field, year clamping, leap and century rules,
    // invalid days and months, and pairs whose raw day numbers run backward.
    rows.push_back(known_row(0, 0, 0, 0, 0, 0, 0, ORD_EQUAL, 1'b0, 1'b0));
    rows.push_back(known_row(31, 15, YEAR_TOP, 31, 15, YEAR_TOP, 0, ORD_EQUAL, 1'b0, 1'b0));
    rows.push_back(known_row(1, 1, 9999, 1, 1, YEAR_TOP, 0, ORD_EQUAL, 1'b1, 1'b1));
    rows.push_back(known_row(5, 6, 10000, 5, 6, 9999, 0, ORD_EQUAL, 1'b1, 1'b1));
    rows.push_back(check_row(1, 1, 0, 31, 12, 9999));
    rows.push_back(check_row(31, 12, 9999, 1, 1, 0));
    rows.push_back(known_row(29, 2, 2024, 1, 3, 2024, 1, ORD_EARLIER, 1'b1, 1'b1));
    rows.push_back(known_row(28, 2, 2023, 1, 3, 2023, 1, ORD_EARLIER, 1'b1, 1'b1));
    rows.push_back(known_row(31, 12, 1999, 1, 1, 2000, 1, ORD_EARLIER, 1'b1, 1'b1));
    rows.push_back(known_row(1, 1, 1, 1, 1, 0, 366, ORD_LATER, 1'b1, 1'b1));
    rows.push_back(known_row(29, 2, 0, 1, 3, 0, 1, ORD_EARLIER, 1'b1, 1'b1));
    rows.push_back(check_row(29, 2, 2000, 29, 2, 1900));
    rows.push_back(check_row(29, 2, 2100, 1, 3, 2100));
    rows.push_back(known_row(5, 0, 2000, 5, 1, 2000, 0, ORD_EARLIER, 1'b0, 1'b1));
    rows.push_back(check_row(0, 5, 2020, 30, 4, 2020));
    rows.push_back(check_row(31, 2, 2021, 1, 3, 2021));
    rows.push_back(check_row(15, 13, 2020, 15, 15, 2020));
    rows.push_back(check_row(1, 14, 9998, 31, 0, 10001));
    rows.push_back(known_row(31, 1, 2001, 30, 1, 2001, 1, ORD_LATER, 1'b1, 1'b1));
    rows.push_back(known_row(31, 4, 2022, 31, 4, 2022, 0, ORD_EQUAL, 1'b0, 1'b0));
    rows.push_back(known_row(30, 4, 2022, 31, 4, 2022, 1, ORD_EARLIER, 1'b1, 1'b0));
    rows.push_back(check_row(16, 8, 5461, 15, 7, 10922));

    // Reset is held low at the start of the run and never asserted again.
    repeat (10) @(posedge clk);
    rst_n     <= 1'b1;
    stall_pct <= 5;
    gaps_on    = 1'b1;

    foreach (rows[i]) begin
      send_pair(rows[i].pair, rows[i].typed ? rows[i].golden : predict_gap(rows[i].pair));
    end
    settle();

    // The random part runs in phases of different pressure: no gaps and no
    // stalls, gaps with light stalls, or gaps with heavy stalls.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k >= RANDOM_ITEMS - CALM_TAIL) begin
        stall_pct <= 0;
        gaps_on    = 1'b0;
      end else if (k % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            stall_pct <= 0;
            gaps_on    = 1'b0;
          end
          1: begin
            stall_pct <= 5;
            gaps_on    = 1'b1;
          end
          default: begin
            stall_pct <= 25;
            gaps_on    = 1'b1;
          end
        endcase
      end
      // Halfway through, the pipeline is drained completely once.
      if (k == RANDOM_ITEMS / 2) begin
        settle();
      end
      p = random_pair();
      send_pair(p, predict_gap(p));
    end

    in_valid  <= 1'b0;
    stall_pct <= 0;
    while (gaps_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (miss_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side.
  // ---------------------------------------------------------------------------

  // Random stall bursts, started with the chance set by the current phase.
  // A burst that has begun always runs to its end.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result transfer is compared field by field with the oldest pending
  // expectation. A result with nothing pending counts as a mismatch too.
  always @(posedge clk) begin
    cdd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (gaps_due.size() == 0) begin
        miss_count++;
        if (miss_count <= 10) begin
          $display("unexpected result: day_count %0d order %0d valid %b/%b",
                   out_data.day_count, out_data.order,
                   out_data.first_valid, out_data.second_valid);
        end
      end else begin
        want = gaps_due.pop_front();
        if (out_data.day_count !== want.day_count || out_data.order !== want.order ||
            out_data.first_valid !== want.first_valid ||
            out_data.second_valid !== want.second_valid) begin
          miss_count++;
          if (miss_count <= 10) begin
            $display("mismatch: expected day_count %0d order %0d valid %b/%b, got %0d %0d %b/%b",
                     want.day_count, want.order, want.first_valid, want.second_valid,
                     out_data.day_count, out_data.order,
                     out_data.first_valid, out_data.second_valid);
          end
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// File: files.f
src/cdd_pkg.sv
src/calendar_day_difference_unit.sv
src/cdd_checker.sv
dv/tb.sv
